/* rtl/core/lrupr_pkg.sv */
package lrupr_pkg;

   localparam int FRAMES    = 16;
   localparam int PAGE_BITS = 16;
   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W    = IDX_W;
   localparam int CNT_W     = 5;
   localparam int FAULT_W   = 32;

   localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(FRAMES - 1);
   localparam logic [RANK_W:0]   RANK_OPEN = (RANK_W + 1)'(FRAMES);

   // Search record that walks down the row of frame cells, one cell per cycle.
   typedef struct packed {
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic                 final_ref;
      logic                 hit_found;
      logic [IDX_W-1:0]     hit_idx;
      logic [RANK_W-1:0]    hit_rank;
      logic                 empty_found;
      logic [IDX_W-1:0]     empty_idx;
      logic                 lru_found;
      logic [IDX_W-1:0]     lru_idx;
      logic [RANK_W-1:0]    lru_rank;
      logic [PAGE_BITS-1:0] lru_page;
   } search_type;

   // Update broadcast to every cell at the end of a lookup.
   typedef struct packed {
      logic                 en;
      logic                 clear;
      logic [IDX_W-1:0]     idx;
      logic                 write;
      logic [PAGE_BITS-1:0] page;
      logic [RANK_W:0]      limit;
   } update_type;

endpackage

/* rtl/core/lrupr_cell.sv */
module lrupr_cell import lrupr_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_use,
   input  logic       stall,
   input  search_type rec_in,
   input  update_type upd,
   output search_type rec_out
);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 filled_ff;
   logic                 filled_in;
   logic [RANK_W-1:0]    rank_ff;
   logic [RANK_W-1:0]    rank_in;
   search_type           rec_ff;
   search_type           rec_in_next;
   logic                 match;
   logic                 is_target;

   assign match     = in_use && filled_ff && (page_ff == rec_in.page);
   assign is_target = (upd.idx == IDX_W'(INDEX));

   // Fold this frame into the running search result.
   always_comb begin
      rec_in_next = rec_in;
      if (rec_in.valid) begin
         if (match && !rec_in.hit_found) begin
            rec_in_next.hit_found = 1'b1;
            rec_in_next.hit_idx   = IDX_W'(INDEX);
            rec_in_next.hit_rank  = rank_ff;
         end
         if (in_use && !filled_ff && !rec_in.empty_found) begin
            rec_in_next.empty_found = 1'b1;
            rec_in_next.empty_idx   = IDX_W'(INDEX);
         end
         // Strictly greater keeps the lowest index among equal ranks.
         if (in_use && filled_ff && (!rec_in.lru_found || rank_ff > rec_in.lru_rank)) begin
            rec_in_next.lru_found = 1'b1;
            rec_in_next.lru_idx   = IDX_W'(INDEX);
            rec_in_next.lru_rank  = rank_ff;
            rec_in_next.lru_page  = page_ff;
         end
      end
   end

   always_comb begin
      filled_in = filled_ff;
      rank_in   = rank_ff;
      if (upd.en) begin
         if (upd.clear) begin
            filled_in = 1'b0;
            rank_in   = '0;
         end else if (is_target) begin
            rank_in = '0;
            if (upd.write) begin
               filled_in = 1'b1;
            end
         end else if (in_use && filled_ff && ({1'b0, rank_ff} < upd.limit)
                      && (rank_ff != RANK_MAX)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= 1'b0;
         rank_ff      <= '0;
         rec_ff.valid <= 1'b0;
      end else begin
         filled_ff <= filled_in;
         rank_ff   <= rank_in;
         if (!stall) begin
            rec_ff <= rec_in_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en && !upd.clear && is_target && upd.write) begin
         page_ff <= upd.page;
      end
   end

   assign rec_out = rec_ff;

endmodule

/* rtl/core/lru_page_replacement.sv */
// Channel  Dir  Beat contents
// req      in   tdata[15:0] page_number; tlast final_reference
// rsp      out  tdata[0] hit, [4:1] frame_index, [5] evicted_valid,
//               [21:6] evicted_page, [53:22] fault_count; tlast is_final
// csr      in   wr_data[4:0] frames_in_use, taken whenever wr_en is high
//
// A reference walks the row of 16 frame cells one cell per clock; the table update
// and the result load happen together, once the last cell holds it and rsp can take
// the result. A new reference can be taken the cycle after its predecessor's result is
// loaded, never before. Reset empties every frame and zeroes the fault count;
// frames_in_use returns to 16. While the result beat waits on rsp_tready the search
// holds in the last cell and the table is not updated.
module lru_page_replacement import lrupr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // page_number
   input  logic        req_tlast,   // final_reference
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // hit, frame_index, evicted_valid, evicted_page,
                                    // fault_count, then zero fill
   output logic        rsp_tlast,   // is_final
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // frames_in_use
);

   logic [CNT_W-1:0]     frames_ff;
   logic [CNT_W-1:0]     frames_eff;
   logic [FRAMES-1:0]    in_use;
   logic                 busy_ff;
   logic                 busy_in;
   logic [FAULT_W-1:0]   faults_ff;
   logic [FAULT_W-1:0]   faults_in;
   logic [FAULT_W-1:0]   faults_next;
   logic                 accept;
   logic                 done;
   logic                 stall;
   search_type           chain [FRAMES+1];
   search_type           last;
   update_type           upd;
   logic [FRAMES-1:0]    rec_valids;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0] rsp_ev_page_ff;
   logic [FAULT_W-1:0]   rsp_faults_ff;
   logic                 rsp_final_ff;

   logic [IDX_W-1:0]     sel_idx;
   logic                 ev_valid;

   always_comb begin
      if (frames_ff == '0) begin
         frames_eff = CNT_W'(1);
      end else if (frames_ff > CNT_W'(FRAMES)) begin
         frames_eff = CNT_W'(FRAMES);
      end else begin
         frames_eff = frames_ff;
      end
   end

   assign accept = req_tvalid && req_tready;
   assign last   = chain[FRAMES];
   assign done   = last.valid && (!rsp_valid_ff || rsp_tready);
   assign stall  = last.valid && !done;
   assign req_tready = !busy_ff;

   always_comb begin
      chain[0]           = '0;
      chain[0].valid     = accept;
      chain[0].page      = req_tdata[PAGE_BITS-1:0];
      chain[0].final_ref = req_tlast;
   end

   genvar gi;
   generate
      for (gi = 0; gi < FRAMES; gi++) begin : g_cell
         assign in_use[gi]     = (CNT_W'(gi) < frames_eff);
         assign rec_valids[gi] = chain[gi+1].valid;
         lrupr_cell #(.INDEX(gi)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .in_use  (in_use[gi]),
            .stall   (stall),
            .rec_in  (chain[gi]),
            .upd     (upd),
            .rec_out (chain[gi+1])
         );
      end
   endgenerate

   // Pick the frame: the hit, else the first empty frame, else the oldest one.
   always_comb begin
      ev_valid = !last.hit_found && !last.empty_found;
      if (last.hit_found) begin
         sel_idx = last.hit_idx;
      end else if (last.empty_found) begin
         sel_idx = last.empty_idx;
      end else begin
         sel_idx = last.lru_idx;
      end

      upd       = '0;
      upd.en    = done;
      upd.clear = last.final_ref;
      upd.idx   = sel_idx;
      upd.write = !last.hit_found;
      upd.page  = last.page;
      if (last.hit_found) begin
         upd.limit = {1'b0, last.hit_rank};
      end else if (last.empty_found) begin
         upd.limit = RANK_OPEN;
      end else begin
         upd.limit = {1'b0, last.lru_rank};
      end

      if (last.hit_found || (&faults_ff)) begin
         faults_next = faults_ff;
      end else begin
         faults_next = faults_ff + 1'b1;
      end

      faults_in = faults_ff;
      if (done) begin
         faults_in = last.final_ref ? '0 : faults_next;
      end

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= CNT_W'(FRAMES);
         busy_ff      <= 1'b0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frames_ff <= csr_wr_data;
         end
         busy_ff   <= busy_in;
         faults_ff <= faults_in;
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_hit_ff      <= last.hit_found;
         rsp_idx_ff      <= sel_idx;
         rsp_ev_valid_ff <= ev_valid;
         rsp_ev_page_ff  <= ev_valid ? last.lru_page : '0;
         rsp_faults_ff   <= faults_next;
         rsp_final_ff    <= last.final_ref;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_final_ff;
   assign rsp_tdata  = {2'b00, rsp_faults_ff, rsp_ev_page_ff, rsp_ev_valid_ff,
                        rsp_idx_ff, rsp_hit_ff};

`ifndef SYNTH
   a_one_search: assert property (@(posedge clock) disable iff (reset)
      $onehot0(rec_valids))
      else $error("more than one reference in the frame row");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> rec_valids == '0)
      else $error("reference in the frame row while idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("block not busy after taking a reference");

   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ev_valid_ff |-> !rsp_hit_ff)
      else $error("eviction reported on a hit");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      done && last.final_ref |=> faults_ff == '0)
      else $error("fault count not cleared after the last reference");
`endif

endmodule
